// ===== src/sira_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, job type and digit-to-ASCII mapping for the radix text converter.
// No dependencies.
package sira_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int STORE_DEPTH = VALUE_WIDTH + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    // divider: quotient bits resolved per clock
    localparam int DIV_STEPS   = 4;
    localparam int DIV_W       = ((VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_CYCLES  = DIV_W / DIV_STEPS;
    localparam int DCNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = CHAR_W'(8'h2D);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA = CHAR_W'(8'h37); // 'A' - 10

    // classified number handed from front to back
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mag;
        logic [RADIX_W-1:0]     radix;
        logic                   neg;
    } t_job;

    // digit value 0-35 to '0'-'9', 'A'-'Z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < RADIX_W'(10)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (d < RADIX_MAX) begin
            c = CHAR_ALPHA + CHAR_W'(d);
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// ===== src/sira_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: number input and character output.
// Depends on sira_pkg.
interface sira_in_if;
    import sira_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface sira_out_if;
    import sira_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== src/signed_integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps
// Top level of the signed integer to radix text converter.
// Depends on sira_pkg, sira_if, sira_front, sira_queue, sira_back.

// Converts a signed 32-bit two's complement value into its text in base 2 to 36
// (radix outside that range is clamped), one uppercase ASCII character per
// output transfer, most significant digit first, with a leading '-' for
// negative values and last_char set on the final digit; zero gives "0" and the
// most negative value is converted exactly. The front end takes a number
// whenever its two-entry queue has room. The back end handles one number at a
// time: it takes the job in the idle state, runs the divider once per digit
// (4 quotient bits per cycle), passes through the sign step for every number
// (the '-' goes out in it when present), then sends each digit through a read
// state for the registered digit store read and a send state, and it waits in
// the sign and send steps while the output is stalled.
module signed_integer_to_radix_ascii (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sira_in_if.sink    i_in,
    sira_out_if.source o_out
);
    import sira_pkg::*;

    logic w_push;
    logic w_full;
    logic w_job_valid;
    logic w_pop;
    t_job w_front_job;
    t_job w_back_job;

    sira_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_front_job)
    );

    sira_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_job   (w_back_job),
        .i_pop   (w_pop)
    );

    sira_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_back_job),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule

// ===== src/sira_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts numbers, clamps the radix, splits sign and magnitude.
// Depends on sira_pkg and sira_in_if.
module sira_front (
    sira_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output sira_pkg::t_job   o_job
);
    import sira_pkg::*;

    logic [VALUE_WIDTH-1:0] w_neg_val;

    // transfer whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // magnitude; the most negative value negates to 2^(W-1), exact as unsigned
    assign w_neg_val  = ~i_in.value + VALUE_WIDTH'(1);
    assign o_job.neg  = i_in.value[VALUE_WIDTH-1];
    assign o_job.mag  = i_in.value[VALUE_WIDTH-1] ? w_neg_val : i_in.value;

    // saturate radix to 2..36
    always_comb begin
        if (i_in.radix < RADIX_MIN) begin
            o_job.radix = RADIX_MIN;
        end else if (i_in.radix > RADIX_MAX) begin
            o_job.radix = RADIX_MAX;
        end else begin
            o_job.radix = i_in.radix;
        end
    end

endmodule

// ===== src/sira_queue.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between front and back end.
// Depends on sira_pkg.
module sira_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sira_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output sira_pkg::t_job o_job,
    input  logic           i_pop
);
    import sira_pkg::*;

    t_job       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/sira_back.sv =====
`timescale 1ns / 1ps
// Back end: iterative divider producing digits into a small store, then
// emits sign and digits most significant first through an output register.
// Depends on sira_pkg and sira_out_if.
module sira_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  sira_pkg::t_job i_job,
    output logic           o_pop,
    sira_out_if.source     o_out
);
    import sira_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_SEND = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [DIV_W-1:0]   r_work,  n_work;
    logic [RADIX_W-1:0] r_rem,   n_rem;
    logic [RADIX_W-1:0] r_radix, n_radix;
    logic               r_neg,   n_neg;
    logic [DCNT_W-1:0]  r_dcnt,  n_dcnt;
    logic [IDX_W-1:0]   r_idx,   n_idx;

    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char,  n_out_char;
    logic               r_out_last,  n_out_last;

    logic [RADIX_W-1:0] r_store [STORE_DEPTH];
    logic [RADIX_W-1:0] r_rd_data;
    logic               w_we;

    logic [RADIX_W-1:0] s_rem;
    logic [DIV_W-1:0]   s_work;
    logic [RADIX_W:0]   s_cat;
    logic               w_out_free;

    assign o_out.valid     = r_out_valid;
    assign o_out.text_char = r_out_char;
    assign o_out.last_char = r_out_last;
    assign w_out_free      = !r_out_valid || o_out.ready;

    // restoring division, DIV_STEPS quotient bits per clock
    always_comb begin
        s_rem  = r_rem;
        s_work = r_work;
        s_cat  = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            s_cat  = {s_rem, s_work[DIV_W-1]};
            s_work = {s_work[DIV_W-2:0], 1'b0};
            if (s_cat >= {1'b0, r_radix}) begin
                s_rem     = RADIX_W'(s_cat - {1'b0, r_radix});
                s_work[0] = 1'b1;
            end else begin
                s_rem = s_cat[RADIX_W-1:0];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_neg       = r_neg;
        n_dcnt      = r_dcnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_work  = DIV_W'(i_job.mag);
                    n_radix = i_job.radix;
                    n_neg   = i_job.neg;
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_idx   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_work = s_work;
                n_rem  = s_rem;
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(DIV_CYCLES - 1)) begin
                    // one digit done: store remainder, continue on quotient
                    w_we   = 1'b1;
                    n_rem  = '0;
                    n_dcnt = '0;
                    if (s_work == '0) begin
                        n_state = S_SIGN;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_SIGN: begin
                if (!r_neg) begin
                    n_state = S_READ;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(r_rd_data);
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_rem      <= n_rem;
        r_radix    <= n_radix;
        r_neg      <= n_neg;
        r_dcnt     <= n_dcnt;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // digit store, least significant digit at index 0
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_idx] <= s_rem;
        end
        r_rd_data <= r_store[r_idx];
    end

endmodule
